// ----- rtl/frx_pkg.sv -----
// ============================================================================
// frx_pkg
// Shared types, command codes and checksum helper for the Fletcher-16
// checked packet receiver.
// ============================================================================
`default_nettype none

package frx_pkg;

   // Packet framing: three checked bytes and then two checksum bytes.
   localparam int unsigned PacketSize  = 5;
   localparam int unsigned PosWidth    = 3;
   localparam logic [PosWidth-1:0] PosCheckHigh = PosWidth'(PacketSize - 2);
   localparam logic [PosWidth-1:0] PosLast      = PosWidth'(PacketSize - 1);

   // Depth of the queue between the front and back parts.
   localparam int unsigned QueueDepth  = 2;

   // Command codes carried in the first byte of a packet.
   localparam logic [7:0] CODE_HEARTBEAT = 8'h01;
   localparam logic [7:0] CODE_FORWARD   = 8'h02;
   localparam logic [7:0] CODE_ROTATE    = 8'h04;
   localparam logic [7:0] CODE_ACK       = 8'h08;
   localparam logic [7:0] CODE_LIFT      = 8'h10;
   localparam logic [7:0] CODE_SCORE     = 8'h20;

   localparam logic [15:0] DropCountMax = 16'hFFFF;

   // Classification reported with each packet.
   typedef enum logic [2:0] {
      KIND_BAD       = 3'd0,
      KIND_HEARTBEAT = 3'd1,
      KIND_ACTION    = 3'd2,
      KIND_ACK       = 3'd3,
      KIND_UNKNOWN   = 3'd4
   } kind_type;

   // One complete packet handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] command;
      logic [7:0] number;
      logic [7:0] payload;
      logic       good;
   } entry_type;

   // Addition modulo 255, where 0xFF counts as zero.
   function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 9'd255) s = s - 9'd255;
      if (s >= 9'd255) s = s - 9'd255;
      return s[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/frx_front.sv -----
// ============================================================================
// frx_front
// Byte framer: tracks the position within a packet, keeps the running
// Fletcher-16 sums and pushes each complete packet with its check result.
// ============================================================================
`default_nettype none

module frx_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_rx_byte,
   input  wire logic             q_full,
   output logic                  push,
   output frx_pkg::entry_type    push_entry
);
   import frx_pkg::*;

   logic [PosWidth-1:0] byte_position_ff, byte_position_in;
   logic [7:0]          sum_low_ff, sum_low_in;
   logic [7:0]          sum_high_ff, sum_high_in;
   logic [7:0]          held_command_ff, held_command_in;
   logic [7:0]          held_number_ff, held_number_in;
   logic [7:0]          held_payload_ff, held_payload_in;
   logic [7:0]          held_check_high_ff, held_check_high_in;
   logic                accept;
   logic                last_byte;

   // Only the final byte needs room in the queue.
   assign last_byte = (byte_position_ff >= PosLast);
   assign req_ready = !last_byte || !q_full;
   assign accept    = req_valid && req_ready;

   // The finished packet goes to the queue together with its check result.
   assign push               = accept && last_byte;
   assign push_entry.command = held_command_ff;
   assign push_entry.number  = held_number_ff;
   assign push_entry.payload = held_payload_ff;
   assign push_entry.good    = ({held_check_high_ff, req_rx_byte} == {sum_high_ff, sum_low_ff});

   // Next state of the framer.
   always_comb begin
      byte_position_in   = byte_position_ff;
      sum_low_in         = sum_low_ff;
      sum_high_in        = sum_high_ff;
      held_command_in    = held_command_ff;
      held_number_in     = held_number_ff;
      held_payload_in    = held_payload_ff;
      held_check_high_in = held_check_high_ff;
      if (accept) begin
         if (byte_position_ff < PosCheckHigh) begin
            case (byte_position_ff)
               PosWidth'(0): held_command_in = req_rx_byte;
               PosWidth'(1): held_number_in  = req_rx_byte;
               default:      held_payload_in = req_rx_byte;
            endcase
            sum_low_in       = add_mod255(sum_low_ff, req_rx_byte);
            sum_high_in      = add_mod255(sum_high_ff, sum_low_in);
            byte_position_in = byte_position_ff + PosWidth'(1);
         end else if (byte_position_ff == PosCheckHigh) begin
            held_check_high_in = req_rx_byte;
            byte_position_in   = byte_position_ff + PosWidth'(1);
         end else begin
            byte_position_in = '0;
            sum_low_in       = '0;
            sum_high_in      = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         sum_low_ff       <= '0;
         sum_high_ff      <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
         sum_low_ff       <= sum_low_in;
         sum_high_ff      <= sum_high_in;
      end
   end

   // Held packet bytes need no reset.
   always_ff @(posedge clock) begin
      held_command_ff    <= held_command_in;
      held_number_ff     <= held_number_in;
      held_payload_ff    <= held_payload_in;
      held_check_high_ff <= held_check_high_in;
   end

endmodule

`default_nettype wire

// ----- rtl/frx_queue.sv -----
// ============================================================================
// frx_queue
// Short first-in first-out queue of complete packets between the framer
// and the dispatcher.
// ============================================================================
`default_nettype none

module frx_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire frx_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output frx_pkg::entry_type      head_entry
);
   import frx_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   entry_type             store_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full       = (count_ff == CntWidth'(QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer and fill level update; the depth is a power of two so the
   // pointers wrap by themselves.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/frx_back.sv -----
// ============================================================================
// frx_back
// Packet dispatcher: classifies each queued packet, keeps the drop counter
// and the acknowledge sequence number, and holds the result word.
// ============================================================================
`default_nettype none

module frx_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               not_empty,
   input  wire frx_pkg::entry_type head_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_command,
   output logic [7:0]              rsp_sender_seq,
   output logic [7:0]              rsp_payload,
   output logic                    rsp_ack_send,
   output logic [7:0]              rsp_ack_sequence,
   output logic [15:0]             rsp_ack_checksum,
   output logic [15:0]             rsp_dropped_count
);
   import frx_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  transmit_sequence_ff, transmit_sequence_in;
   logic [15:0] drop_counter_ff, drop_counter_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  command_ff, number_ff, payload_ff;
   logic        ack_send_ff, ack_send_in;
   logic [7:0]  ack_sequence_ff, ack_sequence_in;
   logic [15:0] ack_checksum_ff, ack_checksum_in;
   logic [7:0]  ack_lo2, ack_hi2, ack_lo3, ack_hi3;

   // A new word is taken when the result register is empty or being emptied.
   assign pop = not_empty && (!rsp_valid_ff || rsp_ready);

   // Fletcher-16 of the acknowledge code, our sequence and the packet number.
   // After the code byte both sums equal the code itself.
   always_comb begin
      ack_lo2 = add_mod255(CODE_ACK, transmit_sequence_ff);
      ack_hi2 = add_mod255(CODE_ACK, ack_lo2);
      ack_lo3 = add_mod255(ack_lo2, head_entry.number);
      ack_hi3 = add_mod255(ack_hi2, ack_lo3);
   end

   // Classification and state update for the word at the head of the queue.
   always_comb begin
      kind_in              = KIND_BAD;
      ack_send_in          = 1'b0;
      ack_sequence_in      = '0;
      ack_checksum_in      = '0;
      transmit_sequence_in = transmit_sequence_ff;
      drop_counter_in      = drop_counter_ff;
      if (!head_entry.good) begin
         if (drop_counter_ff != DropCountMax) begin
            drop_counter_in = drop_counter_ff + 16'd1;
         end
      end else begin
         case (head_entry.command)
            CODE_HEARTBEAT: kind_in = KIND_HEARTBEAT;
            CODE_FORWARD, CODE_ROTATE, CODE_LIFT, CODE_SCORE: begin
               kind_in              = KIND_ACTION;
               ack_send_in          = 1'b1;
               ack_sequence_in      = transmit_sequence_ff;
               ack_checksum_in      = {ack_hi3, ack_lo3};
               transmit_sequence_in = transmit_sequence_ff + 8'd1;
            end
            CODE_ACK:       kind_in = KIND_ACK;
            default:        kind_in = KIND_UNKNOWN;
         endcase
      end
   end

   // Result register handshake.
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff         <= 1'b0;
         transmit_sequence_ff <= '0;
         drop_counter_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            transmit_sequence_ff <= transmit_sequence_in;
            drop_counter_ff      <= drop_counter_in;
         end
      end
   end

   // Result payload; loaded only when a word is taken.
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff         <= kind_in;
         command_ff      <= head_entry.command;
         number_ff       <= head_entry.number;
         payload_ff      <= head_entry.payload;
         ack_send_ff     <= ack_send_in;
         ack_sequence_ff <= ack_sequence_in;
         ack_checksum_ff <= ack_checksum_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_command       = command_ff;
   assign rsp_sender_seq    = number_ff;
   assign rsp_payload       = payload_ff;
   assign rsp_ack_send      = ack_send_ff;
   assign rsp_ack_sequence  = ack_sequence_ff;
   assign rsp_ack_checksum  = ack_checksum_ff;
   assign rsp_dropped_count = drop_counter_ff;

endmodule

`default_nettype wire

// ----- rtl/fletcher_packet_receiver_unit.sv -----
// Result path: the fifth byte of a packet goes into the packet queue, and the
// result register is loaded from the queue head once that register is free.
// Throughput: one byte per cycle; the framer only stalls on a packet's last byte
// when the two-entry packet queue is full.
// Reset: synchronous, active high; clears packet position, sums, sequence number,
// drop counter and the queue. Held packet bytes are not reset.
// ============================================================================
// fletcher_packet_receiver_unit
// Deframes 5-byte packets with a Fletcher-16 check, classifies them and
// reports acknowledge details and the dropped-packet count.
// ============================================================================
`default_nettype none

module fletcher_packet_receiver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_sender_seq,
   output logic [7:0]       rsp_payload,
   output logic             rsp_ack_send,
   output logic [7:0]       rsp_ack_sequence,
   output logic [15:0]      rsp_ack_checksum,
   output logic [15:0]      rsp_dropped_count
);
   import frx_pkg::*;

   logic      push;
   logic      q_full;
   logic      pop;
   logic      q_not_empty;
   entry_type push_entry;
   entry_type head_entry;

   // Front part: framing and checksum.
   frx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Packet queue between the two parts.
   frx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   // Back part: classification and result register.
   frx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (q_not_empty),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_command       (rsp_command),
      .rsp_sender_seq    (rsp_sender_seq),
      .rsp_payload       (rsp_payload),
      .rsp_ack_send      (rsp_ack_send),
      .rsp_ack_sequence  (rsp_ack_sequence),
      .rsp_ack_checksum  (rsp_ack_checksum),
      .rsp_dropped_count (rsp_dropped_count)
   );

endmodule

`default_nettype wire

// ----- tb/tb_fletcher_packet_receiver_unit.sv -----
// ============================================================================
// Testbench for the Fletcher-16 checked packet receiver
// Drives received words into the block and tracks packet framing, running
// sums, the acknowledge sequence and the drop counter alongside it. Every
// report the block returns is compared field by field with the oldest
// prediction. The test tasks cover directed packets, wrap of the acknowledge
// sequence, and random framed traffic with noise and back-pressure.
// ============================================================================
module tb_fletcher_packet_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import frx_pkg::*;

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned LongHoldOff   = 300;
   localparam int unsigned RandomWords   = 200;
   localparam int unsigned WrapPackets   = 256;
   localparam logic [7:0]  AllOnes       = 8'hFF;

   // One predicted packet report.
   typedef struct {
      kind_type    kind;
      logic [7:0]  command;
      logic [7:0]  number;
      logic [7:0]  payload;
      logic        ack_send;
      logic [7:0]  ack_sequence;
      logic [15:0] ack_checksum;
      logic [15:0] dropped;
   } packet_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_sender_seq;
   logic [7:0]  rsp_payload;
   logic        rsp_ack_send;
   logic [7:0]  rsp_ack_sequence;
   logic [15:0] rsp_ack_checksum;
   logic [15:0] rsp_dropped_count;

   // Framing tracker state, kept in step with every accepted word.
   logic [2:0]  frame_pos = '0;
   logic [7:0]  sum_low = '0;
   logic [7:0]  sum_high = '0;
   logic [7:0]  got_command = '0;
   logic [7:0]  got_number = '0;
   logic [7:0]  got_payload = '0;
   logic [7:0]  got_check_high = '0;
   logic [7:0]  ack_counter = '0;
   logic [15:0] drop_total = '0;

   packet_report_type pending_reports[$];

   int unsigned failures = 0;
   int unsigned words_sent = 0;
   int unsigned idle_cycles = 0;
   int unsigned sink_wait = 0;
   int unsigned sink_hold = 0;
   bit          pace_sender = 1'b0;
   bit          pace_sink = 1'b0;

   fletcher_packet_receiver_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_command       (rsp_command),
      .rsp_sender_seq    (rsp_sender_seq),
      .rsp_payload       (rsp_payload),
      .rsp_ack_send      (rsp_ack_send),
      .rsp_ack_sequence  (rsp_ack_sequence),
      .rsp_ack_checksum  (rsp_ack_checksum),
      .rsp_dropped_count (rsp_dropped_count)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sum modulo 255; an all-ones byte counts as zero.
   function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
      return 8'((int'(a) + int'(b)) % 255);
   endfunction

   // Fletcher-16 over three bytes, second sum in the upper byte.
   function automatic logic [15:0] fletcher16_of(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = mod255_add(8'd0, a);
      hi = lo;
      lo = mod255_add(lo, b);
      hi = mod255_add(hi, lo);
      lo = mod255_add(lo, c);
      hi = mod255_add(hi, lo);
      return {hi, lo};
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_action_code();
      case ($urandom_range(0, 3))
         0: return CODE_FORWARD;
         1: return CODE_ROTATE;
         2: return CODE_LIFT;
         default: return CODE_SCORE;
      endcase
   endfunction

   // Command mix weighted towards action codes, with any byte now and then.
   function automatic logic [7:0] pick_command();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return pick_action_code();
      if (roll < 65) return CODE_HEARTBEAT;
      if (roll < 75) return CODE_ACK;
      return 8'($urandom_range(0, 255));
   endfunction

   // Advance the framing tracker by one word and queue a report at the
   // end of each packet.
   task automatic absorb_word(input logic [7:0] w);
      packet_report_type r;
      logic [15:0]       received;
      if (frame_pos < PosCheckHigh) begin
         case (frame_pos)
            3'd0: got_command = w;
            3'd1: got_number = w;
            default: got_payload = w;
         endcase
         sum_low = mod255_add(sum_low, w);
         sum_high = mod255_add(sum_high, sum_low);
         frame_pos = frame_pos + 3'd1;
      end else if (frame_pos == PosCheckHigh) begin
         got_check_high = w;
         frame_pos = frame_pos + 3'd1;
      end else begin
         received = {got_check_high, w};
         r.kind = KIND_BAD;
         r.command = got_command;
         r.number = got_number;
         r.payload = got_payload;
         r.ack_send = 1'b0;
         r.ack_sequence = '0;
         r.ack_checksum = '0;
         if (received != {sum_high, sum_low}) begin
            if (drop_total != DropCountMax) drop_total = drop_total + 16'd1;
         end else begin
            case (got_command)
               CODE_HEARTBEAT: r.kind = KIND_HEARTBEAT;
               CODE_FORWARD, CODE_ROTATE, CODE_LIFT, CODE_SCORE: begin
                  r.kind = KIND_ACTION;
                  r.ack_send = 1'b1;
                  r.ack_sequence = ack_counter;
                  r.ack_checksum = fletcher16_of(CODE_ACK, ack_counter, got_number);
                  ack_counter = ack_counter + 8'd1;
               end
               CODE_ACK: r.kind = KIND_ACK;
               default: r.kind = KIND_UNKNOWN;
            endcase
         end
         r.dropped = drop_total;
         frame_pos = '0;
         sum_low = '0;
         sum_high = '0;
         pending_reports.push_back(r);
      end
   endtask

   // Offer one word, wait for it to be taken, then idle if pacing is on.
   task automatic send_word(input logic [7:0] w);
      int unsigned gap;
      req_valid <= 1'b1;
      req_rx_byte <= w;
      do @(posedge clock); while (!req_ready);
      absorb_word(w);
      words_sent++;
      gap = pace_sender ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_packet(input logic [7:0] c, input logic [7:0] n, input logic [7:0] p,
                              input logic [15:0] chk);
      send_word(c);
      send_word(n);
      send_word(p);
      send_word(chk[15:8]);
      send_word(chk[7:0]);
   endtask

   task automatic send_good(input logic [7:0] c, input logic [7:0] n, input logic [7:0] p);
      send_packet(c, n, p, fletcher16_of(c, n, p));
   endtask

   // A checksum that differs from the true one in at least one bit.
   task automatic send_bad(input logic [7:0] c, input logic [7:0] n, input logic [7:0] p);
      send_packet(c, n, p, fletcher16_of(c, n, p) ^ 16'($urandom_range(1, 65535)));
   endtask

   // Stop offering words until every predicted report has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Directed packets: each class, extreme bytes and an impossible checksum.
   task automatic test_directed();
      pace_sender = 1'b0;
      pace_sink = 1'b0;
      send_good(CODE_HEARTBEAT, 8'h00, 8'h00);
      send_good(CODE_FORWARD, AllOnes, AllOnes);
      send_good(CODE_ACK, 8'h80, 8'h7F);
      // All-ones words add nothing to the sums, so the checksum is zero.
      send_good(AllOnes, AllOnes, AllOnes);
      send_packet(CODE_SCORE, 8'h01, 8'hFE, {AllOnes, AllOnes});
      pause_until_drained();
   endtask

   // Enough action commands to take the acknowledge sequence past 255.
   task automatic test_sequence_wrap();
      pace_sender = 1'b0;
      pace_sink = 1'b1;
      for (int i = 0; i < WrapPackets; i++)
         send_good(pick_action_code(), 8'($urandom), 8'($urandom));
      pause_until_drained();
   endtask

   // Mostly well-formed packets, some with bad checksums, some stray words
   // that shift the framing. Pacing changes every so often.
   task automatic test_random_traffic();
      int unsigned first_word;
      int unsigned packets;
      int unsigned roll;
      first_word = words_sent;
      packets = 0;
      while (words_sent - first_word < RandomWords) begin
         if (packets % 10 == 0) begin
            pace_sender = ($urandom_range(0, 3) != 0);
            pace_sink = ($urandom_range(0, 3) != 0);
         end
         // Long hold-off at the result side while words keep coming.
         if (packets == 10) sink_hold = LongHoldOff;
         if (packets == 30) pause_until_drained();
         roll = $urandom_range(0, 99);
         if (roll < 75)
            send_good(pick_command(), 8'($urandom), 8'($urandom));
         else if (roll < 90)
            send_bad(pick_command(), 8'($urandom), 8'($urandom));
         else
            repeat ($urandom_range(1, 4)) send_word(8'($urandom));
         packets++;
      end
      pause_until_drained();
   endtask

   // Result-side pacing: random stalls plus the long hold-off on request.
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         sink_wait = sink_hold;
         sink_hold = 0;
      end else if (sink_wait == 0 && pace_sink && $urandom_range(0, 9) == 0) begin
         sink_wait = pick_gap();
      end
      if (sink_wait != 0) begin
         rsp_ready <= 1'b0;
         sink_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each report taken with the oldest prediction.
   always @(posedge clock) begin : report_checker
      packet_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report, command %0h", rsp_command);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("command", 16'(want.command), 16'(rsp_command));
            check_field("sender_seq", 16'(want.number), 16'(rsp_sender_seq));
            check_field("payload", 16'(want.payload), 16'(rsp_payload));
            check_field("ack_send", 16'(want.ack_send), 16'(rsp_ack_send));
            check_field("ack_sequence", 16'(want.ack_sequence), 16'(rsp_ack_sequence));
            check_field("ack_checksum", want.ack_checksum, rsp_ack_checksum);
            check_field("dropped_count", want.dropped, rsp_dropped_count);
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_sequence_wrap();
      test_random_traffic();
      // Let any stray report show up before the verdict.
      repeat (20) @(posedge clock);
      if (failures == 0 && pending_reports.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/frx_pkg.sv
rtl/frx_front.sv
rtl/frx_queue.sv
rtl/frx_back.sv
rtl/fletcher_packet_receiver_unit.sv
tb/tb_fletcher_packet_receiver_unit.sv
